// File: design/ppdv_pkg.sv
// Shared types and constants for the pinhole projection / depth visibility block.
// No dependencies; imported by every module of the block.
package ppdv_pkg;

  localparam int ImgWidthDefault  = 256;
  localparam int ImgHeightDefault = 256;
  localparam int NumRegs          = 8;
  localparam int CfgIndexW        = 4;
  localparam int AddrW            = 16;
  localparam int HalfQ            = 32768;

  localparam logic [CfgIndexW-1:0] REG_ROW0_XY    = 4'd0;
  localparam logic [CfgIndexW-1:0] REG_ROW0_ZT    = 4'd1;
  localparam logic [CfgIndexW-1:0] REG_ROW1_XY    = 4'd2;
  localparam logic [CfgIndexW-1:0] REG_ROW1_ZT    = 4'd3;
  localparam logic [CfgIndexW-1:0] REG_ROW2_XY    = 4'd4;
  localparam logic [CfgIndexW-1:0] REG_ROW2_ZT    = 4'd5;
  localparam logic [CfgIndexW-1:0] REG_FOCAL      = 4'd6;
  localparam logic [CfgIndexW-1:0] REG_PRINCIPAL  = 4'd7;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TEST  = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [31:0]        vertex_tag;
    logic [15:0]        pixel_address;
    logic signed [31:0] depth_value;
  } in_t;

  typedef struct packed {
    logic [31:0]        tag_out;
    logic               visible;
    logic               on_image;
    logic signed [31:0] pixel_col;
    logic signed [31:0] pixel_row;
    logic signed [31:0] projected_depth;
    logic [31:0]        visible_total;
  } out_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: design/ppdv_mul.sv
// Shared 32x32 signed multiplier with a registered product.
// Depends on ppdv_pkg.
module ppdv_mul import ppdv_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: design/ppdv_div.sv
// Iterative signed divider, one quotient bit per cycle, positive divisor.
// Quotient truncates toward zero. Depends on ppdv_pkg.
module ppdv_div import ppdv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               done,
  output logic signed [63:0] quotient
);

  logic        busy;
  logic [6:0]  cnt;
  logic        neg;
  logic [63:0] dq;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh   = {rem, dq[63]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign quotient = neg ? -$signed(dq) : $signed(dq);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        neg  <= dividend[63];
        dq   <= dividend[63] ? 64'(-dividend) : 64'(dividend);
        rem  <= '0;
        dvs  <= 32'(divisor);
      end else if (busy) begin
        rem <= fits ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
        dq  <= {dq[62:0], fits};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: design/pinhole_projection_depth_visibility.sv
// Pinhole projection with depth-map visibility test, one shared multiplier and divider.
// A depth write goes straight to its result; a vertex with positive depth passes the transform
// steps, two multiply-divide passes (column, then row), then read, compare and output; a vertex
// with depth of zero or less goes from the transform steps to its result.
// One item at a time: the next item is taken only after the result is issued.
// Reset (synchronous, active high) clears the config registers, the state and the visible count;
// the depth map is not cleared and must be written before it is read.
module pinhole_projection_depth_visibility import ppdv_pkg::*; #(
  parameter int IMG_WIDTH  = ImgWidthDefault,
  parameter int IMG_HEIGHT = ImgHeightDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_XFORM = 3'd1;
  localparam logic [2:0] S_PMUL  = 3'd2;
  localparam logic [2:0] S_PDIV  = 3'd3;
  localparam logic [2:0] S_MEM   = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]  state;
  logic [3:0]  cnt;
  logic        sel;            // 0 while working on column, 1 on row
  logic [63:0] cfg [NumRegs];

  // item registers
  logic signed [31:0] px, py, pz;
  logic [31:0]        tag;
  logic signed [31:0] xc, yc, zc;
  logic signed [31:0] col, row;
  logic signed [49:0] acc;
  logic               on, vis;
  logic [31:0]        count;

  // depth map
  logic [31:0]        mem [2**AddrW];
  logic [31:0]        mem_q;
  logic [AddrW-1:0]   rd_addr;
  logic [31:0]        addr_full;

  // shared units
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic               div_start, div_done;
  logic signed [63:0] quot;

  logic in_acc;
  logic out_free;

  // hold off items during reset and while one is in work
  assign in_stall  = rst || (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = !rst;

  ppdv_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  ppdv_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod),
    .divisor(zc), .done(div_done), .quotient(quot)
  );

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) cfg[i] <= '0;
    end else if (cfg_valid && cfg_ready && cfg_index < CfgIndexW'(NumRegs)) begin
      cfg[cfg_index[2:0]] <= cfg_data;
    end
  end

  // depth map: write on accepted depth items, registered read every cycle
  assign addr_full = 32'(row) * 32'(IMG_WIDTH) + 32'(col);
  assign rd_addr   = addr_full[AddrW-1:0];

  always_ff @(posedge clk) begin
    if (in_acc && in_item.func == FUNC_WRITE) begin
      mem[in_item.pixel_address] <= in_item.depth_value;
    end
    mem_q <= mem[rd_addr];
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_XFORM) begin
      case (cnt)
        4'd0: begin mul_a = cfg[REG_ROW0_XY[2:0]][63:32]; mul_b = px; end
        4'd1: begin mul_a = cfg[REG_ROW0_XY[2:0]][31:0];  mul_b = py; end
        4'd2: begin mul_a = cfg[REG_ROW0_ZT[2:0]][63:32]; mul_b = pz; end
        4'd3: begin mul_a = cfg[REG_ROW1_XY[2:0]][63:32]; mul_b = px; end
        4'd4: begin mul_a = cfg[REG_ROW1_XY[2:0]][31:0];  mul_b = py; end
        4'd5: begin mul_a = cfg[REG_ROW1_ZT[2:0]][63:32]; mul_b = pz; end
        4'd6: begin mul_a = cfg[REG_ROW2_XY[2:0]][63:32]; mul_b = px; end
        4'd7: begin mul_a = cfg[REG_ROW2_XY[2:0]][31:0];  mul_b = py; end
        4'd8: begin mul_a = cfg[REG_ROW2_ZT[2:0]][63:32]; mul_b = pz; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else begin
      mul_a = sel ? yc : xc;
      mul_b = sel ? cfg[REG_FOCAL[2:0]][31:0] : cfg[REG_FOCAL[2:0]][63:32];
    end
  end

  // transform step: floor the finished product and add it in
  logic signed [47:0] prod_fl;
  logic signed [31:0] t_sel;
  logic signed [31:0] coord;
  logic               last_term;

  assign prod_fl = prod[63:16];
  always_comb begin
    unique case (cnt)
      4'd3:    t_sel = cfg[REG_ROW0_ZT[2:0]][31:0];
      4'd6:    t_sel = cfg[REG_ROW1_ZT[2:0]][31:0];
      default: t_sel = cfg[REG_ROW2_ZT[2:0]][31:0];
    endcase
  end
  assign last_term = (cnt == 4'd3) || (cnt == 4'd6) || (cnt == 4'd9);
  assign coord     = sat32(66'(acc + 50'(prod_fl) + 50'(t_sel)));

  // projection finish: add principal point, round half away from zero, saturate
  logic signed [31:0] pp_sel;
  logic signed [65:0] qsum;
  logic        [65:0] qmag;
  logic        [65:0] qrnd;
  logic signed [65:0] qres;
  logic signed [31:0] pix;

  assign pp_sel = sel ? cfg[REG_PRINCIPAL[2:0]][31:0] : cfg[REG_PRINCIPAL[2:0]][63:32];
  assign qsum   = 66'(quot) + 66'(pp_sel);
  assign qmag   = qsum[65] ? 66'(-qsum) : 66'(qsum);
  assign qrnd   = (qmag + 66'(HalfQ)) >> 16;
  assign qres   = qsum[65] ? -$signed(qrnd) : $signed(qrnd);
  assign pix    = sat32(qres);

  // depth tolerance check
  logic signed [32:0] dd;
  logic               in_bounds;

  assign dd = 33'(zc) - 33'($signed(mem_q));
  assign in_bounds = (col >= 0) && (col < 32'(IMG_WIDTH)) &&
                     (row >= 0) && (row < 32'(IMG_HEIGHT));

  assign div_start = (state == S_PMUL) && (cnt == 4'd1);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      sel       <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop a taken result unless a new one is issued on this edge
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            px  <= in_item.point_x;
            py  <= in_item.point_y;
            pz  <= in_item.point_z;
            cnt <= '0;
            sel <= 1'b0;
            acc <= '0;
            col <= '0;
            row <= '0;
            on  <= 1'b0;
            vis <= 1'b0;
            if (in_item.func == FUNC_TEST) begin
              tag   <= in_item.vertex_tag;
              state <= S_XFORM;
            end else begin
              tag   <= '0;
              zc    <= '0;
              state <= S_FIN;
            end
          end
        end
        S_XFORM: begin
          if (cnt != 4'd9) cnt <= cnt + 4'd1;
          if (cnt != 4'd0) begin
            if (last_term) begin
              acc <= '0;
              if (cnt == 4'd3) xc <= coord;
              else if (cnt == 4'd6) yc <= coord;
              else begin
                zc    <= coord;
                cnt   <= '0;
                // non-positive depth skips projection
                state <= (coord > 0) ? S_PMUL : S_FIN;
              end
            end else begin
              acc <= acc + 50'(prod_fl);
            end
          end
        end
        S_PMUL: begin
          // issue product, then hand it to the divider
          if (cnt == 4'd1) begin
            cnt   <= '0;
            state <= S_PDIV;
          end else begin
            cnt <= 4'd1;
          end
        end
        S_PDIV: begin
          if (div_done) begin
            if (!sel) begin
              col   <= pix;
              sel   <= 1'b1;
              state <= S_PMUL;
            end else begin
              row   <= pix;
              state <= S_MEM;
            end
          end
        end
        S_MEM: begin
          // wait for the registered depth read
          state <= S_CMP;
        end
        S_CMP: begin
          if (in_bounds) begin
            on <= 1'b1;
            if (dd < 33'sd32768 && dd > -33'sd32768) begin
              vis   <= 1'b1;
              count <= count + 32'd1;
            end
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid                <= 1'b1;
            out_item.tag_out         <= tag;
            out_item.visible         <= vis;
            out_item.on_image        <= on;
            out_item.pixel_col       <= col;
            out_item.pixel_row       <= row;
            out_item.projected_depth <= zc;
            out_item.visible_total   <= count;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: dv/tb_top.sv
// Testbench for pinhole_projection_depth_visibility: a projection and depth-test predictor
// in a small scoreboard class, random and directed items, and cfg writes while idle.
// Depends on ppdv_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_top;
  import ppdv_pkg::*;

  localparam int W = ImgWidthDefault;
  localparam int H = ImgHeightDefault;
  localparam int WatchLimit = 20000;

  // Hold the camera, the depth map and the running count, and queue the expected results.
  class vis_scoreboard;
    logic [63:0] regs [NumRegs];
    logic [31:0] depth_map [int];
    logic [31:0] vis_count;
    out_t        pending [$];
    int          errors;

    function void clear();
      foreach (regs[i]) regs[i] = '0;
      vis_count = '0;
      errors = 0;
    endfunction

    function void add_expected(out_t e);
      pending.insert(pending.size(), e);
    endfunction

    function longint hi(int r);
      return longint'($signed(regs[r][63:32]));
    endfunction

    function longint lo(int r);
      return longint'($signed(regs[r][31:0]));
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Arithmetic shift floors toward minus infinity.
    function longint camera_axis(int row, longint x, longint y, longint z);
      return clamp32(((hi(2*row) * x) >>> 16) + ((lo(2*row) * y) >>> 16)
                     + ((hi(2*row+1) * z) >>> 16) + lo(2*row+1));
    endfunction

    function longint to_pixel(longint c, longint f, longint p, longint zc);
      longint q, m;
      q = (c * f) / zc + p;
      m = q < 0 ? -q : q;
      m = (m + HalfQ) >>> 16;
      return clamp32(q < 0 ? -m : m);
    endfunction

    // Depth map address a vertex item will read, or -1 when it reads none.
    function int read_addr(in_t it, output longint zc);
      longint x, y, z, xc, yc, col, row;
      x = it.point_x; y = it.point_y; z = it.point_z;
      xc = camera_axis(0, x, y, z);
      yc = camera_axis(1, x, y, z);
      zc = camera_axis(2, x, y, z);
      if (it.func != FUNC_TEST || zc <= 0) return -1;
      col = to_pixel(xc, hi(REG_FOCAL), hi(REG_PRINCIPAL), zc);
      row = to_pixel(yc, lo(REG_FOCAL), lo(REG_PRINCIPAL), zc);
      if (col >= 0 && col < W && row >= 0 && row < H)
        return int'((row * W + col) & 64'hFFFF);
      return -1;
    endfunction

    function void note_item(in_t it);
      out_t e;
      longint x, y, z, xc, yc, zc, col, row, d;
      int addr;
      e = '0;
      if (it.func == FUNC_WRITE) begin
        depth_map[it.pixel_address] = it.depth_value;
        e.visible_total = vis_count;
        add_expected(e);
        return;
      end
      x = it.point_x; y = it.point_y; z = it.point_z;
      xc = camera_axis(0, x, y, z);
      yc = camera_axis(1, x, y, z);
      zc = camera_axis(2, x, y, z);
      col = 0; row = 0;
      if (zc > 0) begin
        col = to_pixel(xc, hi(REG_FOCAL), hi(REG_PRINCIPAL), zc);
        row = to_pixel(yc, lo(REG_FOCAL), lo(REG_PRINCIPAL), zc);
        if (col >= 0 && col < W && row >= 0 && row < H) begin
          addr = int'((row * W + col) & 64'hFFFF);
          e.on_image = 1'b1;
          d = zc - longint'($signed(depth_map.exists(addr) ? depth_map[addr] : 32'd0));
          if (d < HalfQ && d > -HalfQ) e.visible = 1'b1;
        end
      end
      if (e.visible) vis_count = vis_count + 1;
      e.tag_out = it.vertex_tag;
      e.pixel_col = col[31:0];
      e.pixel_row = row[31:0];
      e.projected_depth = zc[31:0];
      e.visible_total = vis_count;
      add_expected(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_result(out_t got);
      out_t w;
      if (pending.size() == 0) begin
        report("unexpected result", got.tag_out, '0);
        return;
      end
      w = pending.pop_front();
      if (got.tag_out !== w.tag_out) report("tag_out", got.tag_out, w.tag_out);
      if (got.visible !== w.visible)
        report("visible", 32'(got.visible), 32'(w.visible));
      if (got.on_image !== w.on_image)
        report("on_image", 32'(got.on_image), 32'(w.on_image));
      if (got.pixel_col !== w.pixel_col) report("pixel_col", got.pixel_col, w.pixel_col);
      if (got.pixel_row !== w.pixel_row) report("pixel_row", got.pixel_row, w.pixel_row);
      if (got.projected_depth !== w.projected_depth)
        report("projected_depth", got.projected_depth, w.projected_depth);
      if (got.visible_total !== w.visible_total)
        report("visible_total", got.visible_total, w.visible_total);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  in_t  in_item = '0;
  logic out_valid, out_stall = 0;
  out_t out_item;
  logic cfg_valid = 0, cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  vis_scoreboard sb = new();
  int send_idle_pct = 0, recv_stall_pct = 0;
  int quiet_cycles = 0;

  pinhole_projection_depth_visibility u_dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Sample on the edge, then pick the next stall value with one NBA.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Write one register, then deassert cfg_valid so the next write starts on a fresh edge.
  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [63:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.regs[idx[2:0]] = val;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Present one item, hold it until taken, and note it for prediction.
  task automatic send(in_t it);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1; in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
    in_valid <= 0;
    @(posedge clk);
  endtask

  // Write the pixel a vertex will read when it has not been written yet, then send it.
  task automatic send_vertex(in_t it);
    in_t w;
    longint zc;
    int a;
    a = sb.read_addr(it, zc);
    if (a >= 0 && !sb.depth_map.exists(a)) begin
      w = '0;
      w.func = FUNC_WRITE;
      w.pixel_address = a[15:0];
      w.vertex_tag = $urandom;
      if ($urandom_range(1)) w.depth_value = zc[31:0];
      else w.depth_value = 32'(zc + longint'($urandom_range(131071)) - 64'sd65536);
      send(w);
    end
    send(it);
  endtask

  // Drain, then leave room for any result still in the block.
  task automatic settle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] q(int v);
    return v <<< 16;
  endfunction

  // Identity rotation, translation tz on z, focal f, principal at image center; rand_all randomizes every register.
  task automatic load_camera(int f, int tz, bit rand_all);
    logic [63:0] v [NumRegs];
    v[REG_ROW0_XY] = {q(1), q(0)};
    v[REG_ROW0_ZT] = {q(0), q(0)};
    v[REG_ROW1_XY] = {q(0), q(1)};
    v[REG_ROW1_ZT] = {q(0), q(0)};
    v[REG_ROW2_XY] = {q(0), q(0)};
    v[REG_ROW2_ZT] = {q(1), q(tz)};
    v[REG_FOCAL] = {q(f), q(f)};
    v[REG_PRINCIPAL] = {q(W/2), q(H/2)};
    if (rand_all) foreach (v[i]) v[i] = {$urandom, $urandom};
    for (int i = 0; i < NumRegs; i++) write_reg(i[CfgIndexW-1:0], v[i]);
  endtask

  function automatic in_t vertex(int x, int y, int z);
    in_t it;
    it = '0;
    it.func = FUNC_TEST;
    it.point_x = x; it.point_y = y; it.point_z = z;
    it.vertex_tag = $urandom;
    it.pixel_address = $urandom; it.depth_value = $urandom;
    return it;
  endfunction

  task automatic random_vertex(bit wild);
    in_t it;
    int zq;
    if (wild) begin
      it = vertex($urandom, $urandom, $urandom);
    end else begin
      zq = $urandom_range(3*65536, 6*65536);
      it = vertex($urandom_range(0, 2*zq) - zq, $urandom_range(0, 2*zq) - zq, zq);
      if ($urandom_range(1)) it.point_z = q(4) + $urandom_range(65535) - 32768;
    end
    send_vertex(it);
  endtask

  task automatic random_write();
    in_t it;
    it = '0;
    it.func = FUNC_WRITE;
    it.point_x = $urandom; it.point_y = $urandom; it.point_z = $urandom;
    it.vertex_tag = $urandom;
    it.pixel_address = $urandom;
    it.depth_value = $urandom;
    send(it);
  endtask

  initial begin
    in_t it;
    sb.clear();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: writes at the address extremes and field extremes.
    it = '0; it.func = FUNC_WRITE; it.pixel_address = 16'h0000; it.depth_value = 32'h80000000;
    send(it);
    it.pixel_address = 16'hFFFF; it.depth_value = 32'h7FFFFFFF; it.vertex_tag = '1;
    it.point_x = '1; it.point_y = '1; it.point_z = '1;
    send(it);
    // Zero camera: depth exactly zero, not visible.
    send_vertex(vertex(q(1), q(1), q(1)));
    send_vertex(vertex(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    settle();

    // Center pixel at depth 4 exactly, for the tolerance edges below.
    load_camera(64, 0, 0);
    it = '0; it.func = FUNC_WRITE; it.pixel_address = 16'((H/2) * W + W/2);
    it.depth_value = q(4);
    send(it);

    send_vertex(vertex(0, 0, q(4)));              // center, visible
    send_vertex(vertex(0, 0, q(5)));              // depth off by one, on image only
    send_vertex(vertex(0, 0, -q(4)));             // negative depth
    send_vertex(vertex(q(100), 0, q(4)));         // off the right edge
    send_vertex(vertex(-q(100), -q(100), q(4)));  // off the top-left
    send_vertex(vertex(-q(8), -q(8), q(4)));      // corner pixel 0,0
    send_vertex(vertex(32'sh7FFFFFFF, 32'sh80000000, 1)); // saturated pixel
    send_vertex(vertex(q(1) + 32'h8000, 0, q(64)));       // rounding half way
    send_vertex(vertex(-q(1) - 32'h8000, 0, q(64)));
    send_vertex(vertex(0, 0, q(4) + 32'h7FFF));   // just inside tolerance
    send_vertex(vertex(0, 0, q(4) + 32'h8000));   // just outside
    settle();

    // Random phases; each one picks an idling pattern and a camera.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (ph == 5) load_camera(0, 0, 1);
      else if (ph == 6) begin
        write_reg(REG_FOCAL, {32'h7FFFFFFF, 32'h80000000});
        write_reg(REG_PRINCIPAL, {32'h80000000, 32'h7FFFFFFF});
      end else load_camera($urandom_range(16, 128), $urandom_range(0, 2), 0);
      for (int n = 0; n < 65; n++) begin
        if (n == 32) while (sb.pending.size() != 0) @(posedge clk);
        case ($urandom_range(9))
          0: random_write();
          1: random_vertex(1);
          default: random_vertex(0);
        endcase
      end
      settle();
    end

    if (sb.errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule

// File: pinhole_projection_depth_visibility.f
design/ppdv_pkg.sv
design/ppdv_mul.sv
design/ppdv_div.sv
design/pinhole_projection_depth_visibility.sv
dv/tb_top.sv
